@@ rtl/conv3x3_normalized_filter_core_assert.svh @@
// Assertion macros shared by the checker of the 3x3 convolution core.
`ifndef CONV3X3_NORMALIZED_FILTER_CORE_ASSERT_SVH
`define CONV3X3_NORMALIZED_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define C3NF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c3nf: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define C3NF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c3nf: next-cycle check failed");

`endif

@@ rtl/c3nf_pkg.sv @@
// Types, constants and register codes of the 3x3 convolution core.
package c3nf_pkg;

  localparam int MAX_LINE_LEN_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 10;
  localparam int LL_W       = 11;
  localparam int COEF_ROW_W = 24;
  localparam int COEF_W     = 8;
  localparam int MIN_DIM    = 3;
  localparam int N_TAPS     = 9;
  localparam int TAP_W      = $clog2(N_TAPS);
  localparam int PROD_W     = 2 * PIX_W + 1;
  localparam int SUM_W      = 20;
  localparam int K_W        = 12;
  localparam int DIVD_W     = SUM_W - 1;
  localparam int DIVS_W     = K_W - 1;
  localparam int STEP_W     = $clog2(DIVD_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_ROW_W;

  localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST = 24'hFFFFFF;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RST = 24'hFF00FF;
  localparam logic [COEF_ROW_W-1:0] COEF_BOT_RST = 24'hFFFFFF;
  localparam logic [LL_W-1:0]       LL_RST       = 11'd512;
  localparam logic [ROW_W-1:0]      LC_RST       = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_TOP = 3'd0,
    CFG_COEF_MID = 3'd1,
    CFG_COEF_BOT = 3'd2,
    CFG_LINE_LEN = 3'd3,
    CFG_LINE_CNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_ROW_W-1:0] coef_top;
    logic [COEF_ROW_W-1:0] coef_mid;
    logic [COEF_ROW_W-1:0] coef_bot;
    logic [LL_W-1:0]       line_length;
    logic [ROW_W-1:0]      line_count;
  } cfg_t;

  typedef struct packed {
    logic [N_TAPS-1:0][PIX_W-1:0] pix;
    logic [ROW_W-1:0]             row;
    logic [OUT_COL_W-1:0]         col;
    logic                         last;
  } job_t;

  typedef struct packed {
    logic             empty;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

@@ rtl/c3nf_in_if.sv @@
// Input pixel channel with valid/ready handshake.
interface c3nf_in_if;
  logic                        valid;
  logic                        ready;
  logic [c3nf_pkg::PIX_W-1:0]  pixel_in;
  logic                        frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

@@ rtl/c3nf_out_if.sv @@
// Output result channel with valid/ready handshake.
interface c3nf_out_if;
  logic                            valid;
  logic                            ready;
  logic [c3nf_pkg::PIX_W-1:0]      pixel_out;
  logic [c3nf_pkg::ROW_W-1:0]      out_row;
  logic [c3nf_pkg::OUT_COL_W-1:0]  out_col;
  logic                            last_of_frame;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output last_of_frame, input ready);
  modport sink (input valid, input pixel_out, input out_row, input out_col,
                input last_of_frame, output ready);
endinterface

@@ rtl/c3nf_ram.sv @@
// Generic simple dual-port RAM with registered read.
module c3nf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/c3nf_fifo.sv @@
// Short job queue between the window front end and the arithmetic back end.
module c3nf_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  c3nf_pkg::job_t         push_job,
  input  logic                   pop,
  output c3nf_pkg::job_t         pop_job,
  output c3nf_pkg::fifo_stat_t   stat
);
  c3nf_pkg::job_t                  mem [c3nf_pkg::QUEUE_DEPTH];
  logic [c3nf_pkg::PTR_W-1:0]      head;
  logic [c3nf_pkg::PTR_W-1:0]      tail;
  logic [c3nf_pkg::CNT_W-1:0]      count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_job    = mem[head];
  assign stat.empty = (count == '0);
  assign stat.count = count;
endmodule

@@ rtl/c3nf_front.sv @@
// Front end: position counters, line stores and the 3x3 window; queues interior jobs.
module c3nf_front #(
  parameter int MAX_LINE_LEN = c3nf_pkg::MAX_LINE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  c3nf_in_if.sink               pix_in,
  input  c3nf_pkg::cfg_t        cfg,
  input  c3nf_pkg::fifo_stat_t  qstat,
  output logic                  push,
  output c3nf_pkg::job_t        push_job
);
  localparam int CW = $clog2(MAX_LINE_LEN);
  localparam int LW = (CW + 1 > c3nf_pkg::LL_W) ? CW + 1 : c3nf_pkg::LL_W;
  localparam int PW = c3nf_pkg::PIX_W;
  localparam int RW = c3nf_pkg::ROW_W;

  logic [LW-1:0]     ll_ext;
  logic [LW-1:0]     len_eff;
  logic [RW-1:0]     cnt_eff;
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col_cur;
  logic [RW-1:0]     row_cur;
  logic [LW-1:0]     col_ext;
  logic [LW-1:0]     col_inc;
  logic [LW-1:0]     col_dec;
  logic [RW:0]       row_inc;
  logic              col_wrap;
  logic              produce;
  logic              last;
  logic              fire;
  logic [c3nf_pkg::CNT_W-1:0] occ;

  logic              b_valid;
  logic              b_produce;
  logic              b_last;
  logic [PW-1:0]     b_px;
  logic [CW-1:0]     b_col;
  logic [RW-1:0]     b_row_out;
  logic [c3nf_pkg::OUT_COL_W-1:0] b_col_out;
  logic              b_hit;
  logic [2*PW-1:0]   b_fwd;
  logic [2*PW-1:0]   ram_q;
  logic [PW-1:0]     up2;
  logic [PW-1:0]     up1;

  logic [c3nf_pkg::N_TAPS-1:0][PW-1:0] win;
  logic [c3nf_pkg::N_TAPS-1:0][PW-1:0] win_next;

  always_comb begin
    ll_ext = LW'(cfg.line_length);
    if (ll_ext < LW'(c3nf_pkg::MIN_DIM)) begin
      len_eff = LW'(c3nf_pkg::MIN_DIM);
    end else if (ll_ext > LW'(MAX_LINE_LEN)) begin
      len_eff = LW'(MAX_LINE_LEN);
    end else begin
      len_eff = ll_ext;
    end
    if (cfg.line_count < RW'(c3nf_pkg::MIN_DIM)) begin
      cnt_eff = RW'(c3nf_pkg::MIN_DIM);
    end else begin
      cnt_eff = cfg.line_count;
    end
  end

  always_comb begin
    col_cur  = pix_in.frame_start ? '0 : col;
    row_cur  = pix_in.frame_start ? '0 : row;
    col_ext  = LW'(col_cur);
    col_inc  = col_ext + 1'b1;
    col_dec  = col_ext - 1'b1;
    row_inc  = {1'b0, row_cur} + 1'b1;
    col_wrap = (col_inc >= len_eff);
    produce  = (row_cur >= RW'(2)) && (col_ext >= LW'(2)) &&
               (row_cur < cnt_eff) && (col_ext < len_eff);
    last     = (row_cur == cnt_eff - 1'b1) && (col_ext == len_eff - 1'b1);
  end

  // An item entering the second stage may still need a queue slot.
  assign occ          = qstat.count + {{(c3nf_pkg::CNT_W-1){1'b0}}, b_valid & b_produce};
  assign pix_in.ready = (occ < c3nf_pkg::CNT_W'(c3nf_pkg::QUEUE_DEPTH));
  assign fire         = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      b_valid   <= 1'b0;
      b_produce <= 1'b0;
    end else begin
      b_valid <= fire;
      if (fire) begin
        b_produce <= produce;
        if (col_wrap) begin
          col <= '0;
          row <= (row_inc >= {1'b0, cnt_eff}) ? '0 : row_inc[RW-1:0];
        end else begin
          col <= col_inc[CW-1:0];
          row <= row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_px      <= pix_in.pixel_in;
      b_col     <= col_cur;
      b_row_out <= row_cur - 1'b1;
      b_col_out <= col_dec[c3nf_pkg::OUT_COL_W-1:0];
      b_last    <= last;
      b_hit     <= b_valid && (b_col == col_cur);
      b_fwd     <= {up1, b_px};
    end
  end

  // The older line store sits in the upper byte, the newer one in the lower byte.
  c3nf_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_LINE_LEN)
  ) u_lines (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata ({up1, b_px}),
    .raddr (col_cur),
    .rdata (ram_q)
  );

  assign up2 = b_hit ? b_fwd[2*PW-1:PW] : ram_q[2*PW-1:PW];
  assign up1 = b_hit ? b_fwd[PW-1:0]    : ram_q[PW-1:0];

  always_comb begin
    win_next = win;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3 + 1];
      win_next[r*3 + 1] = win[r*3 + 2];
    end
    win_next[2] = up2;
    win_next[5] = up1;
    win_next[8] = b_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (b_valid) begin
      win <= win_next;
    end
  end

  assign push          = b_valid && b_produce;
  assign push_job.pix  = win_next;
  assign push_job.row  = b_row_out;
  assign push_job.col  = b_col_out;
  assign push_job.last = b_last;
endmodule

@@ rtl/c3nf_back.sv @@
// Back end: serial multiply-accumulate over the window and a bit-serial signed divider.
module c3nf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  c3nf_pkg::cfg_t        cfg,
  input  c3nf_pkg::fifo_stat_t  qstat,
  input  c3nf_pkg::job_t        pop_job,
  output logic                  pop,
  c3nf_out_if.source            pix_out
);
  localparam int PW = c3nf_pkg::PIX_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                                state;
  c3nf_pkg::job_t                        job;
  logic [c3nf_pkg::TAP_W-1:0]            tap;
  logic signed [c3nf_pkg::SUM_W-1:0]     acc;
  logic [c3nf_pkg::DIVS_W-1:0]           rem;
  logic [c3nf_pkg::DIVD_W-1:0]           dq;
  logic [c3nf_pkg::DIVS_W-1:0]           dvs;
  logic [c3nf_pkg::STEP_W-1:0]           step;
  logic                                  neg;
  logic [PW-1:0]                         res;

  logic [c3nf_pkg::N_TAPS-1:0][c3nf_pkg::COEF_W-1:0] coefs;
  logic signed [c3nf_pkg::K_W-1:0]       k;
  logic signed [c3nf_pkg::PROD_W-1:0]    prod;
  logic signed [c3nf_pkg::SUM_W-1:0]     acc_neg;
  logic signed [c3nf_pkg::K_W-1:0]       k_neg;
  logic [c3nf_pkg::DIVS_W:0]             rem_sh;
  logic [c3nf_pkg::DIVS_W:0]             rem_diff;
  logic                                  q_bit;
  logic [c3nf_pkg::DIVD_W-1:0]           dq_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coefs[c]     = cfg.coef_top[8*c +: 8];
      coefs[3 + c] = cfg.coef_mid[8*c +: 8];
      coefs[6 + c] = cfg.coef_bot[8*c +: 8];
    end
    k = '0;
    for (int i = 0; i < c3nf_pkg::N_TAPS; i++) begin
      k = k + c3nf_pkg::K_W'($signed(coefs[i]));
    end
  end

  assign prod     = $signed({1'b0, job.pix[tap]}) * $signed(coefs[tap]);
  assign acc_neg  = -acc;
  assign k_neg    = -k;
  assign rem_sh   = {rem, dq[c3nf_pkg::DIVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign q_bit    = (rem_sh >= {1'b0, dvs});
  assign dq_next  = {dq[c3nf_pkg::DIVD_W-2:0], q_bit};

  assign pop = (state == ST_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (tap == c3nf_pkg::TAP_W'(c3nf_pkg::N_TAPS - 1)) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= (k == '0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (step == c3nf_pkg::STEP_W'(c3nf_pkg::DIVD_W - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (pix_out.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job <= pop_job;
        tap <= '0;
        acc <= '0;
      end
      ST_MAC: begin
        acc <= acc + c3nf_pkg::SUM_W'(prod);
        tap <= tap + 1'b1;
      end
      ST_SETUP: begin
        res  <= acc[PW-1:0];
        rem  <= '0;
        step <= '0;
        neg  <= acc[c3nf_pkg::SUM_W-1] ^ k[c3nf_pkg::K_W-1];
        dq   <= acc[c3nf_pkg::SUM_W-1] ? acc_neg[c3nf_pkg::DIVD_W-1:0]
                                       : acc[c3nf_pkg::DIVD_W-1:0];
        dvs  <= k[c3nf_pkg::K_W-1] ? k_neg[c3nf_pkg::DIVS_W-1:0] : k[c3nf_pkg::DIVS_W-1:0];
      end
      ST_DIV: begin
        rem  <= q_bit ? rem_diff[c3nf_pkg::DIVS_W-1:0] : rem_sh[c3nf_pkg::DIVS_W-1:0];
        dq   <= dq_next;
        step <= step + 1'b1;
        res  <= neg ? (~dq_next[PW-1:0] + 1'b1) : dq_next[PW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign pix_out.valid         = (state == ST_OUT);
  assign pix_out.pixel_out     = res;
  assign pix_out.out_row       = job.row;
  assign pix_out.out_col       = job.col;
  assign pix_out.last_of_frame = job.last;
endmodule

@@ rtl/conv3x3_normalized_filter_core.sv @@
// Top level of the 3x3 normalized convolution core: register file and front/back ends.
// An accepted interior pixel yields its result word via the job queue and the back end; the
// divider is skipped if the coefficient sum is zero. Border pixels are taken one per cycle
// while the queue has room; a result takes 9 serial multiply-accumulate and 19 divider steps.
// A four-entry job queue lets the front keep taking pixels while the back end works.
// Reset clears counters, window, queue, back end and registers; line stores are not cleared.
module conv3x3_normalized_filter_core #(
  parameter int MAX_LINE_LEN = c3nf_pkg::MAX_LINE_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  c3nf_in_if.sink                            pix_in,
  c3nf_out_if.source                         pix_out,
  input  logic                               cfg_write,
  input  logic [c3nf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3nf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  c3nf_pkg::cfg_t        cfg;
  c3nf_pkg::fifo_stat_t  qstat;
  c3nf_pkg::job_t        push_job;
  c3nf_pkg::job_t        pop_job;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_top    <= c3nf_pkg::COEF_TOP_RST;
      cfg.coef_mid    <= c3nf_pkg::COEF_MID_RST;
      cfg.coef_bot    <= c3nf_pkg::COEF_BOT_RST;
      cfg.line_length <= c3nf_pkg::LL_RST;
      cfg.line_count  <= c3nf_pkg::LC_RST;
    end else if (cfg_write) begin
      case (c3nf_pkg::cfg_reg_t'(cfg_index))
        c3nf_pkg::CFG_COEF_TOP: cfg.coef_top    <= cfg_data;
        c3nf_pkg::CFG_COEF_MID: cfg.coef_mid    <= cfg_data;
        c3nf_pkg::CFG_COEF_BOT: cfg.coef_bot    <= cfg_data;
        c3nf_pkg::CFG_LINE_LEN: cfg.line_length <= cfg_data[c3nf_pkg::LL_W-1:0];
        c3nf_pkg::CFG_LINE_CNT: cfg.line_count  <= cfg_data[c3nf_pkg::ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  c3nf_front #(
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .cfg      (cfg),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  c3nf_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (qstat)
  );

  c3nf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .qstat   (qstat),
    .pop_job (pop_job),
    .pop     (pop),
    .pix_out (pix_out)
  );
endmodule

@@ rtl/c3nf_checker.sv @@
// Port-level checker of the 3x3 convolution core and its bind to the top level.
`include "conv3x3_normalized_filter_core_assert.svh"

module c3nf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [c3nf_pkg::PIX_W-1:0]         pixel_out,
  input logic [c3nf_pkg::ROW_W-1:0]         out_row,
  input logic [c3nf_pkg::OUT_COL_W-1:0]     out_col,
  input logic                               last_of_frame
);
  localparam int OW = c3nf_pkg::PIX_W + c3nf_pkg::ROW_W + c3nf_pkg::OUT_COL_W + 1;

  logic [31:0]   in_cnt;
  logic [31:0]   out_cnt;
  logic [OW-1:0] out_word;

  assign out_word = {pixel_out, out_row, out_col, last_of_frame};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      out_cnt <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_cnt <= in_cnt + 1'b1;
      end
      if (out_valid && out_ready) begin
        out_cnt <= out_cnt + 1'b1;
      end
    end
  end

  // A waiting result word keeps its contents until it is taken.
  `C3NF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // Results only come from interior centers, never from the first line or column.
  `C3NF_ASSERT_IMP(a_out_interior, clk, rst, out_valid, out_row != '0 && out_col != '0)

  // Every result word is caused by an earlier accepted pixel word.
  `C3NF_ASSERT_IMP(a_out_causal, clk, rst, out_valid && out_ready, out_cnt < in_cnt)
endmodule

bind conv3x3_normalized_filter_core c3nf_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pix_in.valid),
  .in_ready      (pix_in.ready),
  .out_valid     (pix_out.valid),
  .out_ready     (pix_out.ready),
  .pixel_out     (pix_out.pixel_out),
  .out_row       (pix_out.out_row),
  .out_col       (pix_out.out_col),
  .last_of_frame (pix_out.last_of_frame)
);
